### sv/pip_pkg.sv
// Shared types and constants for the point-in-polygon classifier.
// No dependencies; every other file of the block imports this package.
package pip_pkg;

   localparam int MAX_EDGES  = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_EDGES);
   localparam int CNT_W      = $clog2(MAX_EDGES + 1);
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int EDGE_W     = 4 * COORD_BITS;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic             clear;
      logic             add;
      logic             start;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             load_out;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             busy;
      logic             out_full;
   } status_type;

endpackage

### sv/pip_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on pip_pkg for the coordinate width.
interface pip_req_if import pip_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   opcode;
   logic signed [COORD_BITS-1:0] first_y;
   logic signed [COORD_BITS-1:0] first_z;
   logic signed [COORD_BITS-1:0] second_y;
   logic signed [COORD_BITS-1:0] second_z;

   modport source (output valid, opcode, first_y, first_z, second_y, second_z, input ready);
   modport sink   (input valid, opcode, first_y, first_z, second_y, second_z, output ready);
endinterface

interface pip_rsp_if ();
   logic valid;
   logic ready;
   logic inside_res;
   logic on_edge;
   logic accepted;

   modport source (output valid, inside_res, on_edge, accepted, input ready);
   modport sink   (input valid, inside_res, on_edge, accepted, output ready);
endinterface

### sv/pip_ctrl.sv
// Controller state machine: decodes request transactions and sequences the edge scan.
// Depends on pip_pkg.
module pip_ctrl import pip_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_opcode,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             accept;
   logic             issue;
   logic             finish;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (state_ff == ST_SCAN) && (idx_ff < status.count);
   assign finish    = (state_ff == ST_DRAIN) && !status.busy
                      && !status.out_full;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept && (req_opcode == OP_QUERY)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.clear    = accept && (req_opcode == OP_CLEAR);
      cmd.add      = accept && (req_opcode == OP_ADD);
      cmd.start    = accept && (req_opcode == OP_QUERY);
      cmd.rd_en    = issue;
      cmd.rd_addr  = idx_ff[IDX_W-1:0];
      cmd.load_out = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

### sv/pip_dpath.sv
// Datapath: edge memory, edge count, three-stage edge test pipeline and result register.
// Depends on pip_pkg; driven by commands from pip_ctrl.
module pip_dpath import pip_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  logic signed [COORD_BITS-1:0] first_y,
   input  logic signed [COORD_BITS-1:0] first_z,
   input  logic signed [COORD_BITS-1:0] second_y,
   input  logic signed [COORD_BITS-1:0] second_z,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_inside,
   output logic                         rsp_on_edge
);

   localparam int C = COORD_BITS;

   logic [EDGE_W-1:0] mem [MAX_EDGES];

   logic [CNT_W-1:0]     count_ff, count_in;
   logic signed [C-1:0]  py_ff, pz_ff;
   logic [EDGE_W-1:0]    rd_ff;
   logic                 v1_ff, v2_ff;

   // Stage two: oriented edge, flags and cross products.
   logic signed [C-1:0]      y1, z1, y2, z2, ya, za, yb, zb, left, right;
   logic                     swap, horiz, vert;
   logic signed [DIFF_W-1:0] d_py, d_pz, d_y, d_z;
   logic signed [PROD_W-1:0] p1_in, p2_in, p1_ff, p2_ff;
   logic                     cross_z_in, on_z_in, vert_ff, gen_ff, cross_z_ff, on_z_ff;
   logic                     fixed_on_in, fixed_on_ff;

   logic parity_ff, on_ff;
   logic cross_hit, on_hit;
   logic out_valid_ff, out_inside_ff, out_on_ff;
   logic full;

   assign full = (count_ff == CNT_W'(MAX_EDGES));

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.add && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add && !full) begin
         mem[count_ff[IDX_W-1:0]] <= {first_y, first_z, second_y, second_z};
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
   end

   always_comb begin
      y1    = rd_ff[4*C-1:3*C];
      z1    = rd_ff[3*C-1:2*C];
      y2    = rd_ff[2*C-1:C];
      z2    = rd_ff[C-1:0];
      swap  = z2 < z1;
      ya    = swap ? y2 : y1;
      za    = swap ? z2 : z1;
      yb    = swap ? y1 : y2;
      zb    = swap ? z1 : z2;
      left  = (ya < yb) ? ya : yb;
      right = (ya < yb) ? yb : ya;
      horiz = (za == zb);
      vert  = !horiz && (ya == yb);
      d_py  = DIFF_W'(py_ff) - DIFF_W'(ya);
      d_pz  = DIFF_W'(pz_ff) - DIFF_W'(za);
      d_y   = DIFF_W'(yb) - DIFF_W'(ya);
      d_z   = DIFF_W'(zb) - DIFF_W'(za);
      p1_in = d_py * d_z;
      p2_in = d_pz * d_y;
      cross_z_in  = (pz_ff > za) && (pz_ff <= zb) && (py_ff < right);
      on_z_in     = (pz_ff >= za) && (pz_ff <= zb);
      fixed_on_in = (vert && (py_ff == right))
                    || (horiz && (py_ff >= left) && (py_ff <= right));
   end

   always_ff @(posedge clock) begin
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      vert_ff     <= vert;
      gen_ff      <= !vert && !horiz;
      cross_z_ff  <= cross_z_in;
      on_z_ff     <= on_z_in;
      fixed_on_ff <= fixed_on_in;
      if (cmd.start) begin
         py_ff <= first_y;
         pz_ff <= first_z;
      end
   end

   // Stage three: exact comparisons and accumulation.
   assign cross_hit = cross_z_ff && (vert_ff || (p1_ff <= p2_ff));
   assign on_hit    = on_z_ff && (fixed_on_ff || (gen_ff && (p1_ff == p2_ff)));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         parity_ff <= 1'b0;
         on_ff     <= 1'b0;
      end else if (v2_ff) begin
         parity_ff <= parity_ff ^ cross_hit;
         on_ff     <= on_ff | on_hit;
      end
      if (cmd.load_out) begin
         out_inside_ff <= parity_ff;
         out_on_ff     <= on_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         v1_ff    <= cmd.rd_en;
         v2_ff    <= v1_ff;
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_inside  = out_inside_ff;
   assign rsp_on_edge = out_on_ff;

   always_comb begin
      status.count    = count_ff;
      status.busy     = v1_ff || v2_ff;
      status.out_full = out_valid_ff && !rsp_ready;
   end

endmodule

### sv/point_in_polygon_classifier_top.sv
// A query holds off further requests until its result is loaded into the response register; clear and add do not.
// The scan rate is set by the single read port of the edge memory.
// Synchronous active-high reset empties the edge table and the response register;
// stored edges are not cleared, and only entries below the edge count are ever read.
// Depends on pip_pkg, pip_if, pip_ctrl and pip_dpath.
module point_in_polygon_classifier_top import pip_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pip_req_if.sink   req_chan,
   pip_rsp_if.source rsp_chan
);

   // The controller and datapath exchange only these two bundles.
   cmd_type    cmd;
   status_type status;
   logic       inside_bit;
   logic       on_bit;

   // The controller takes a transaction only when idle. A finished result sits in
   // the response register, so clear, add and even a new query may be taken while
   // the previous response is still waiting; a query finishing in that case
   // holds in its drain state until the register frees up.
   pip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the edge memory and a three-stage pipeline: memory read,
   // orientation and cross products, then the exact compare and accumulation of
   // crossing parity and the on-edge flag.
   pip_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .first_y     (req_chan.first_y),
      .first_z     (req_chan.first_z),
      .second_y    (req_chan.second_y),
      .second_z    (req_chan.second_z),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_inside  (inside_bit),
      .rsp_on_edge (on_bit)
   );

   // A point counts as accepted when it is inside or lies on an edge.
   assign rsp_chan.inside_res = inside_bit;
   assign rsp_chan.on_edge    = on_bit;
   assign rsp_chan.accepted   = inside_bit | on_bit;

endmodule

### sv/pip_checker.sv
// Port-level checker for the point-in-polygon classifier, with its bind statement.
// Depends on pip_pkg and attaches to point_in_polygon_classifier_top.
module pip_checker import pip_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_opcode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_inside,
   input logic       rsp_on_edge,
   input logic       rsp_accepted
);

   logic req_take;

   assign req_take = req_valid && req_ready;

   a_accepted_or: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_inside | rsp_on_edge)))
      else $error("accepted is not inside or on_edge");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response present after reset");

   a_no_rsp_from_table_op: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_opcode != OP_QUERY) && !rsp_valid) |=> !rsp_valid)
      else $error("response produced without a query");

   a_query_not_instant: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_opcode == OP_QUERY) && !rsp_valid) |=> !rsp_valid)
      else $error("query answered before any edge could be scanned");

endmodule

bind point_in_polygon_classifier_top pip_checker u_pip_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_opcode   (req_chan.opcode),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_inside   (rsp_chan.inside_res),
   .rsp_on_edge  (rsp_chan.on_edge),
   .rsp_accepted (rsp_chan.accepted)
);
